// ----- hdl/sht_pkg.sv -----
// shared types and constants for the spatial hash table
// command and status structs between controller and datapath, hash primes
// no dependencies
package sht_pkg;

  localparam int TABLE_BITS_DEF = 16;
  localparam int COORD_BITS_DEF = 16;
  localparam int INDEX_BITS_DEF = 15;

  localparam logic [31:0] PRIME_X = 32'd73856093;
  localparam logic [31:0] PRIME_Y = 32'd19349663;
  localparam logic [31:0] PRIME_Z = 32'd83492791;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_LOOKUP  = 2'd1,
    KIND_SURFACE = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  // face neighbour being probed during a surface test
  typedef enum logic [2:0] {
    NB_XP = 3'd0,
    NB_XM = 3'd1,
    NB_YP = 3'd2,
    NB_YM = 3'd3,
    NB_ZP = 3'd4,
    NB_ZM = 3'd5
  } nb_t;

  typedef enum logic [2:0] {
    ST_INIT  = 3'd0,
    ST_IDLE  = 3'd1,
    ST_SETUP = 3'd2,
    ST_MUL   = 3'd3,
    ST_HASH  = 3'd4,
    ST_PROBE = 3'd5,
    ST_CLEAR = 3'd6,
    ST_DONE  = 3'd7
  } state_t;

  typedef struct packed {
    logic cap;
    logic setq;
    logic mul;
    logic load;
    logic step;
    logic ins_write;
    logic clr_start;
    logic clr_step;
    logic nb_next;
    logic res_found;
    logic res_surface;
    logic res_full;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  rd_valid;
    logic  rd_match;
    logic  probe_last;
    logic  clr_last;
    logic  nb_last;
    logic  out_busy;
  } stat_t;

endpackage

// ----- hdl/sht_ctrl.sv -----
// controller state machine for the spatial hash table
// sequences hashing, probing, inserting and clearing; uses sht_pkg
module sht_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  sht_pkg::stat_t stat,
  output sht_pkg::cmd_t  cmd
);
  import sht_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.cap    = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        case (stat.kind)
          KIND_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next    = ST_CLEAR;
          end
          KIND_INSERT: begin
            if (stat.full) begin
              cmd.res_full = 1'b1;
              state_next   = ST_DONE;
            end else begin
              cmd.setq   = 1'b1;
              state_next = ST_MUL;
            end
          end
          default: begin
            cmd.setq   = 1'b1;
            state_next = ST_MUL;
          end
        endcase
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_HASH;
      end
      ST_HASH: begin
        cmd.load   = 1'b1;
        state_next = ST_PROBE;
      end
      ST_PROBE: begin
        case (stat.kind)
          KIND_INSERT: begin
            if (!stat.rd_valid) begin
              cmd.ins_write = 1'b1;
              state_next    = ST_DONE;
            end else begin
              cmd.step = 1'b1;
            end
          end
          KIND_LOOKUP: begin
            if (stat.rd_valid && stat.rd_match) begin
              cmd.res_found = 1'b1;
              state_next    = ST_DONE;
            end else if (!stat.rd_valid || stat.probe_last) begin
              state_next = ST_DONE;
            end else begin
              cmd.step = 1'b1;
            end
          end
          KIND_SURFACE: begin
            if (stat.rd_valid && stat.rd_match) begin
              if (stat.nb_last) begin
                state_next = ST_DONE;
              end else begin
                cmd.nb_next = 1'b1;
                state_next  = ST_SETUP;
              end
            end else if (!stat.rd_valid || stat.probe_last) begin
              cmd.res_surface = 1'b1;
              state_next      = ST_DONE;
            end else begin
              cmd.step = 1'b1;
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/sht_dp.sv -----
// datapath for the spatial hash table: query registers, hash multipliers,
// slot memories, probe and sweep counters, result and output registers; uses sht_pkg
module sht_dp #(
  parameter int TABLE_BITS = sht_pkg::TABLE_BITS_DEF,
  parameter int COORD_BITS = sht_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = sht_pkg::INDEX_BITS_DEF,
  localparam int IN_W  = ((3 * COORD_BITS + INDEX_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((INDEX_BITS + 3 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic [1:0]       s_tuser,
  input  sht_pkg::cmd_t    cmd,
  output sht_pkg::stat_t   stat,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);
  import sht_pkg::*;

  localparam int TB    = TABLE_BITS;
  localparam int CB    = COORD_BITS;
  localparam int IB    = INDEX_BITS;
  localparam int QW    = CB + 1;
  localparam int EW    = 3 * CB + IB;
  localparam int DEPTH = 1 << TB;

  // captured item
  kind_t                kind;
  logic signed [CB-1:0] bx, by, bz;
  logic [IB-1:0]        bix;
  nb_t                  nb;

  // current query cell, one bit wider so a neighbour never wraps
  logic signed [QW-1:0] qx, qy, qz;
  logic signed [QW-1:0] ox, oy, oz;
  logic [31:0]          qx32, qy32, qz32;
  logic [2*TB-1:0]      px_full, py_full, pz_full;
  logic [TB-1:0]        hx, hy, hz, hash;

  logic [TB-1:0]        probe, pcnt, sweep, rd_addr;
  logic [TB:0]          fill;

  logic [EW-1:0]        ent_mem [DEPTH];
  logic                 valid_mem [DEPTH];
  logic [EW-1:0]        rd_ent;
  logic                 rd_vld;
  logic signed [CB-1:0] sx, sy, sz;

  logic                 res_found, res_surf, res_full;
  logic [IB-1:0]        res_idx;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind <= kind_t'(s_tuser);
      bx   <= s_tdata[0 +: CB];
      by   <= s_tdata[CB +: CB];
      bz   <= s_tdata[2 * CB +: CB];
      bix  <= s_tdata[3 * CB +: IB];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      nb <= NB_XP;
    end else if (cmd.nb_next) begin
      nb <= nb_t'(nb + 3'd1);
    end
  end

  // neighbour offsets, zero unless a surface test
  always_comb begin
    ox = '0;
    oy = '0;
    oz = '0;
    if (kind == KIND_SURFACE) begin
      case (nb)
        NB_XP:   ox = QW'(1);
        NB_XM:   ox = '1;
        NB_YP:   oy = QW'(1);
        NB_YM:   oy = '1;
        NB_ZP:   oz = QW'(1);
        NB_ZM:   oz = '1;
        default: ox = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setq) begin
      qx <= {bx[CB-1], bx} + ox;
      qy <= {by[CB-1], by} + oy;
      qz <= {bz[CB-1], bz} + oz;
    end
  end

  // only the low table bits of each product reach the slot number
  assign qx32    = {{(32 - QW){qx[QW-1]}}, qx};
  assign qy32    = {{(32 - QW){qy[QW-1]}}, qy};
  assign qz32    = {{(32 - QW){qz[QW-1]}}, qz};
  assign px_full = {{TB{1'b0}}, qx32[TB-1:0]} * {{TB{1'b0}}, PRIME_X[TB-1:0]};
  assign py_full = {{TB{1'b0}}, qy32[TB-1:0]} * {{TB{1'b0}}, PRIME_Y[TB-1:0]};
  assign pz_full = {{TB{1'b0}}, qz32[TB-1:0]} * {{TB{1'b0}}, PRIME_Z[TB-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      hx <= px_full[TB-1:0];
      hy <= py_full[TB-1:0];
      hz <= pz_full[TB-1:0];
    end
  end

  assign hash = hx ^ hy ^ hz;

  // read address runs one probe ahead so each cycle checks one slot
  assign rd_addr = cmd.load ? hash : probe + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      probe <= hash;
      pcnt  <= '0;
    end else if (cmd.step) begin
      probe <= probe + 1'b1;
      pcnt  <= pcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      sweep <= '0;
    end else if (cmd.clr_step) begin
      sweep <= sweep + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      fill <= '0;
    end else if (cmd.ins_write) begin
      fill <= fill + 1'b1;
    end
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (cmd.ins_write) begin
      ent_mem[probe] <= {bz, by, bx, bix};
    end
    rd_ent <= ent_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_write) begin
      valid_mem[probe] <= 1'b1;
    end else if (cmd.clr_step) begin
      valid_mem[sweep] <= 1'b0;
    end
    rd_vld <= valid_mem[rd_addr];
  end

  assign sx = rd_ent[IB +: CB];
  assign sy = rd_ent[IB + CB +: CB];
  assign sz = rd_ent[IB + 2 * CB +: CB];

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      res_found <= 1'b0;
      res_idx   <= '0;
      res_surf  <= 1'b0;
      res_full  <= 1'b0;
    end else begin
      if (cmd.res_found) begin
        res_found <= 1'b1;
        res_idx   <= rd_ent[IB-1:0];
      end
      if (cmd.res_surface) begin
        res_surf <= 1'b1;
      end
      if (cmd.res_full) begin
        res_full <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= OUT_W'({res_full, res_surf, res_idx, res_found});
    end
  end

  always_comb begin
    stat.kind       = kind;
    stat.full       = fill[TB];
    stat.rd_valid   = rd_vld;
    stat.rd_match   = ({sx[CB-1], sx} == qx) && ({sy[CB-1], sy} == qy)
                      && ({sz[CB-1], sz} == qz);
    stat.probe_last = &pcnt;
    stat.clr_last   = &sweep;
    stat.nb_last    = (nb == NB_ZM);
    stat.out_busy   = m_tvalid && !m_tready;
  end

endmodule

// ----- hdl/spatial_hash_table.sv -----
// spatial hash table, open addressing with linear probing; top level
// insert and lookup: accept, setup, multiply, hash, then probe slots in turn to a result;
// an insert on a full table is refused at setup; clear sweeps all 2^TABLE_BITS slots
// surface test: setup, multiply, hash and probe run for each of up to 6 neighbours
// one item at a time; the next item is taken in the cycle after the result is loaded
// reset: synchronous; all 2^TABLE_BITS valid bits are swept clear before the first item
module spatial_hash_table #(
  parameter int TABLE_BITS = sht_pkg::TABLE_BITS_DEF,
  parameter int COORD_BITS = sht_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = sht_pkg::INDEX_BITS_DEF,
  localparam int IN_W  = ((3 * COORD_BITS + INDEX_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((INDEX_BITS + 3 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // input items
  input  logic             s_tvalid,
  output logic             s_tready,
  // cell_x, cell_y, cell_z, entry_index, zero fill
  input  logic [IN_W-1:0]  s_tdata,
  // kind
  input  logic [1:0]       s_tuser,
  // result items
  output logic             m_tvalid,
  input  logic             m_tready,
  // found, found_index, on_surface, table_full, zero fill
  output logic [OUT_W-1:0] m_tdata
);
  import sht_pkg::*;

  // command and status between the sequencer and the datapath
  cmd_t  cmd;
  stat_t stat;

  // state machine: reset sweep, hash, probe, insert, clear, hand off result
  sht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot memories, hash multipliers, counters and the output register
  sht_dp #(
    .TABLE_BITS (TABLE_BITS),
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
